// ===== design/nns_pkg.sv =====
// shared types and constants for the nearest neighbor search block
package nns_pkg;

   // field widths fixed by the interface
   localparam int VALUE_W = 16;
   localparam int IDX_W   = 6;
   localparam int CSR_W   = 7;
   localparam int DIST_W  = 38;
   localparam int MAG_W   = 16;
   localparam int SQ_W    = 2 * MAG_W;

   // saturation value of a distance
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // item modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // register indexes
   localparam logic CSR_NUM_ENTRIES = 1'b0;
   localparam logic CSR_NUM_DIMS    = 1'b1;

   // register reset values
   localparam logic [CSR_W-1:0] RESET_NUM_ENTRIES = 7'd2;
   localparam logic [CSR_W-1:0] RESET_NUM_DIMS    = 7'd1;

   // depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // what a queued command asks the back end to do
   typedef struct packed {
      logic wr_ref;
      logic wr_qry;
      logic search;
   } cmd_kind_type;

endpackage

// ===== design/nns_ram.sv =====
// generic single-write, single-read ram with registered read data
module nns_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/nns_front.sv =====
// front end: accepts items, classifies them and queues commands for the back end
module nns_front
   import nns_pkg::*;
#(
   parameter int MAX_ENTRIES = 64,
   parameter int MAX_DIMS    = 64,
   localparam int EW = $clog2(MAX_ENTRIES),
   localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   // item side
   input  logic                      push,
   output logic                      full,
   input  logic                      req_mode,
   input  logic [IDX_W-1:0]          req_entry_index,
   input  logic [IDX_W-1:0]          req_component_index,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last_component,
   // command side
   output logic                      cmd_valid,
   input  logic                      cmd_pop,
   output cmd_kind_type              cmd_kind,
   output logic [EW-1:0]             cmd_entry,
   output logic [DW-1:0]             cmd_comp,
   output logic signed [VALUE_W-1:0] cmd_value
);

   cmd_kind_type               q_kind_ff  [QUEUE_DEPTH];
   logic [EW-1:0]              q_entry_ff [QUEUE_DEPTH];
   logic [DW-1:0]              q_comp_ff  [QUEUE_DEPTH];
   logic signed [VALUE_W-1:0]  q_value_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]            count_ff, count_in;
   logic                       do_push;
   logic                       do_pop;
   logic                       ent_ok;
   logic                       comp_ok;
   cmd_kind_type               kind;

   // classify the incoming item
   always_comb begin
      ent_ok      = (32'(req_entry_index) < MAX_ENTRIES);
      comp_ok     = (32'(req_component_index) < MAX_DIMS);
      kind.wr_ref = (req_mode == MODE_LOAD) && ent_ok && comp_ok;
      kind.wr_qry = (req_mode == MODE_QUERY) && comp_ok;
      kind.search = (req_mode == MODE_QUERY) && req_last_component;
   end

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_kind_ff[wr_ptr_ff]  <= kind;
         q_entry_ff[wr_ptr_ff] <= EW'(req_entry_index);
         q_comp_ff[wr_ptr_ff]  <= DW'(req_component_index);
         q_value_ff[wr_ptr_ff] <= req_value;
      end
   end

   assign cmd_kind  = q_kind_ff[rd_ptr_ff];
   assign cmd_entry = q_entry_ff[rd_ptr_ff];
   assign cmd_comp  = q_comp_ff[rd_ptr_ff];
   assign cmd_value = q_value_ff[rd_ptr_ff];

endmodule

// ===== design/nns_back.sv =====
// back end: table writes, distance pipeline, minimum tracking and result slot
module nns_back
   import nns_pkg::*;
#(
   parameter int MAX_ENTRIES = 64,
   parameter int MAX_DIMS    = 64,
   localparam int EW = $clog2(MAX_ENTRIES),
   localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   // configuration
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [CSR_W-1:0]          csr_wdata,
   // commands from the front end
   input  logic                      cmd_valid,
   output logic                      cmd_pop,
   input  cmd_kind_type              cmd_kind,
   input  logic [EW-1:0]             cmd_entry,
   input  logic [DW-1:0]             cmd_comp,
   input  logic signed [VALUE_W-1:0] cmd_value,
   // result side
   output logic                      empty,
   input  logic                      pop,
   output logic [IDX_W-1:0]          rsp_nearest_index,
   output logic [DIST_W-1:0]         rsp_least_distance
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   // configuration registers, saturated on write
   logic [EW:0]               ents_ff;
   logic [DW:0]               dims_ff;

   logic [1:0]                state_ff, state_in;
   logic [EW-1:0]             e_ff, e_in;
   logic [DW-1:0]             d_ff, d_in;
   logic                      last_d;
   logic                      last_e;
   logic                      start;
   logic                      iss_v;
   logic                      ref_we;
   logic                      qry_we;
   logic [VALUE_W-1:0]        ref_rd;
   logic [VALUE_W-1:0]        qry_rd;

   // pipeline tags and data
   logic                      v1_ff, v2_ff, v3_ff, done4_ff;
   logic                      first1_ff, first2_ff, first3_ff;
   logic                      last1_ff, last2_ff, last3_ff;
   logic [EW-1:0]             e1_ff, e2_ff, e3_ff, e4_ff;
   logic signed [VALUE_W:0]   diff;
   logic [MAG_W-1:0]          mag_in;
   logic [MAG_W-1:0]          mag_ff;
   logic [SQ_W-1:0]           sq_ff;
   logic [DIST_W:0]           sum;
   logic [DIST_W-1:0]         acc_ff, acc_in;
   logic                      pipe_busy;

   // running minimum
   logic [DIST_W-1:0]         best_dist_ff;
   logic [EW-1:0]             best_idx_ff;
   logic                      found_ff;

   // result slot
   logic                      rsp_valid_ff;
   logic [IDX_W-1:0]          rsp_idx_ff;
   logic [DIST_W-1:0]         rsp_dist_ff;
   logic                      slot_free;
   logic                      rsp_load;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ents_ff <= (EW+1)'(RESET_NUM_ENTRIES);
         dims_ff <= (DW+1)'(RESET_NUM_DIMS);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NUM_ENTRIES: begin
               ents_ff <= (32'(csr_wdata) > MAX_ENTRIES) ? (EW+1)'(MAX_ENTRIES)
                                                         : (EW+1)'(csr_wdata);
            end
            CSR_NUM_DIMS: begin
               dims_ff <= (32'(csr_wdata) > MAX_DIMS) ? (DW+1)'(MAX_DIMS)
                                                      : (DW+1)'(csr_wdata);
            end
            default: begin
            end
         endcase
      end
   end

   assign last_d    = (({1'b0, d_ff} + (DW+1)'(1)) == dims_ff);
   assign last_e    = (({1'b0, e_ff} + (EW+1)'(1)) == ents_ff);
   assign pipe_busy = v1_ff || v2_ff || v3_ff || done4_ff;
   assign slot_free = !rsp_valid_ff || pop;

   // sequencer: command execution and the entry-by-component walk
   always_comb begin
      state_in = state_ff;
      e_in     = e_ff;
      d_in     = d_ff;
      cmd_pop  = 1'b0;
      ref_we   = 1'b0;
      qry_we   = 1'b0;
      start    = 1'b0;
      iss_v    = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               ref_we  = cmd_kind.wr_ref;
               qry_we  = cmd_kind.wr_qry;
               if (cmd_kind.search) begin
                  start = 1'b1;
                  e_in  = '0;
                  d_in  = '0;
                  state_in = (ents_ff == '0 || dims_ff == '0) ? ST_DRAIN : ST_RUN;
               end
            end
         end
         ST_RUN: begin
            iss_v = 1'b1;
            if (last_d) begin
               d_in = '0;
               e_in = e_ff + EW'(1);
               if (last_e) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               d_in = d_ff + DW'(1);
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy && slot_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         e_ff     <= '0;
         d_ff     <= '0;
      end else begin
         state_ff <= state_in;
         e_ff     <= e_in;
         d_ff     <= d_in;
      end
   end

   // reference table, entry-major
   nns_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (1 << (EW + DW))
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr ({cmd_entry, cmd_comp}),
      .wr_data (cmd_value),
      .rd_addr ({e_ff, d_ff}),
      .rd_data (ref_rd)
   );

   // query vector
   nns_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (1 << DW)
   ) u_qry_ram (
      .clock   (clock),
      .wr_en   (qry_we),
      .wr_addr (cmd_comp),
      .wr_data (cmd_value),
      .rd_addr (d_ff),
      .rd_data (qry_rd)
   );

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         done4_ff <= 1'b0;
      end else begin
         v1_ff    <= iss_v;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         done4_ff <= v3_ff && last3_ff;
      end
   end

   // difference magnitude of one component pair
   always_comb begin
      diff   = $signed({qry_rd[VALUE_W-1], qry_rd}) - $signed({ref_rd[VALUE_W-1], ref_rd});
      mag_in = diff[VALUE_W] ? MAG_W'(-diff) : MAG_W'(diff);
   end

   // saturating accumulation of squares
   always_comb begin
      sum    = (first3_ff ? '0 : {1'b0, acc_ff}) + (DIST_W+1)'(sq_ff);
      acc_in = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_W-1:0];
   end

   // pipeline data and tags
   always_ff @(posedge clock) begin
      first1_ff <= (d_ff == '0);
      last1_ff  <= last_d;
      e1_ff     <= e_ff;
      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      e2_ff     <= e1_ff;
      mag_ff    <= mag_in;
      first3_ff <= first2_ff;
      last3_ff  <= last2_ff;
      e3_ff     <= e2_ff;
      sq_ff     <= mag_ff * mag_ff;
      e4_ff     <= e3_ff;
      if (v3_ff) begin
         acc_ff <= acc_in;
      end
   end

   // running minimum, strict compare keeps the earliest entry
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (start) begin
         found_ff <= 1'b0;
      end else if (done4_ff && (!found_ff || acc_ff < best_dist_ff)) begin
         found_ff <= 1'b1;
      end
   end

   // zero components with at least one entry gives distance 0, no entries gives all ones
   always_ff @(posedge clock) begin
      if (start) begin
         best_dist_ff <= (ents_ff != '0 && dims_ff == '0) ? '0 : DIST_MAX;
         best_idx_ff  <= '0;
      end else if (done4_ff && (!found_ff || acc_ff < best_dist_ff)) begin
         best_dist_ff <= acc_ff;
         best_idx_ff  <= e4_ff;
      end
   end

   // result slot
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_idx_ff  <= IDX_W'(best_idx_ff);
         rsp_dist_ff <= best_dist_ff;
      end
   end

   assign empty              = !rsp_valid_ff;
   assign rsp_nearest_index  = rsp_idx_ff;
   assign rsp_least_distance = rsp_dist_ff;

endmodule

// ===== design/nearest_neighbor_search.sv =====
// Nearest neighbor search by squared Euclidean distance. Load items (mode 0) write one
// signed component into the reference table; query items (mode 1) write one query
// component, and a query item with last_component set then searches entries
// 0..num_entries-1 over components 0..num_dims-1 and returns one result: the index of
// the closest entry (earliest wins a tie) and its exact distance, saturated to all ones.
// Items enter a four-deep command queue; the back end takes the next command only once
// the current one is done, and a search walks every entry over its components, with
// one table read and one 16x16 multiply per cycle in the distance pipeline. Registers
// above their maximum saturate to MAX_ENTRIES and MAX_DIMS. Table words that were
// never written read as undefined values.
module nearest_neighbor_search
   import nns_pkg::*;
#(
   parameter int MAX_ENTRIES = 64,
   parameter int MAX_DIMS    = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   // configuration port
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [CSR_W-1:0]          csr_wdata,
   // item input
   input  logic                      push,
   output logic                      full,
   input  logic                      req_mode,
   input  logic [IDX_W-1:0]          req_entry_index,
   input  logic [IDX_W-1:0]          req_component_index,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last_component,
   // result output
   output logic                      empty,
   input  logic                      pop,
   output logic [IDX_W-1:0]          rsp_nearest_index,
   output logic [DIST_W-1:0]         rsp_least_distance
);

   localparam int EW = $clog2(MAX_ENTRIES);
   localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

   logic                      cmd_valid;
   logic                      cmd_pop;
   cmd_kind_type              cmd_kind;
   logic [EW-1:0]             cmd_entry;
   logic [DW-1:0]             cmd_comp;
   logic signed [VALUE_W-1:0] cmd_value;

   // item classification and command queue
   nns_front #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .MAX_DIMS    (MAX_DIMS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_mode            (req_mode),
      .req_entry_index     (req_entry_index),
      .req_component_index (req_component_index),
      .req_value           (req_value),
      .req_last_component  (req_last_component),
      .cmd_valid           (cmd_valid),
      .cmd_pop             (cmd_pop),
      .cmd_kind            (cmd_kind),
      .cmd_entry           (cmd_entry),
      .cmd_comp            (cmd_comp),
      .cmd_value           (cmd_value)
   );

   // table storage and search engine
   nns_back #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .MAX_DIMS    (MAX_DIMS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cmd_valid          (cmd_valid),
      .cmd_pop            (cmd_pop),
      .cmd_kind           (cmd_kind),
      .cmd_entry          (cmd_entry),
      .cmd_comp           (cmd_comp),
      .cmd_value          (cmd_value),
      .empty              (empty),
      .pop                (pop),
      .rsp_nearest_index  (rsp_nearest_index),
      .rsp_least_distance (rsp_least_distance)
   );

endmodule

// ===== tb/tb_nearest_neighbor_search.sv =====
// testbench for the nearest neighbor search block: directed table, random phases, predictor
module tb_nearest_neighbor_search;
   import nns_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     HALF_PERIOD = 5;
   localparam int     N_ENTRIES   = 64;
   localparam int     N_DIMS      = 64;
   localparam int     SETTLE      = 20;
   localparam int     NUM_STEPS   = 20;
   localparam longint DIST_TOP    = longint'(DIST_MAX);

   // one input item
   typedef struct packed {
      logic                      mode;
      logic [IDX_W-1:0]          entry;
      logic [IDX_W-1:0]          component;
      logic signed [VALUE_W-1:0] value;
      logic                      last_comp;
   } item_type;

   // one search result
   typedef struct packed {
      logic [IDX_W-1:0]  index;
      logic [DIST_W-1:0] distance;
   } match_type;

   // one row of the directed table
   typedef struct packed {
      logic             is_cfg;
      logic [CSR_W-1:0] n_entries;
      logic [CSR_W-1:0] n_dims;
      item_type         it;
      logic             typed;
      match_type        want;
   } step_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic                      csr_index = CSR_NUM_ENTRIES;
   logic [CSR_W-1:0]          csr_wdata = '0;
   logic                      push = 1'b0;
   logic                      full;
   logic                      req_mode = MODE_LOAD;
   logic [IDX_W-1:0]          req_entry_index = '0;
   logic [IDX_W-1:0]          req_component_index = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      req_last_component = 1'b0;
   logic                      empty;
   logic                      pop = 1'b0;
   logic [IDX_W-1:0]          rsp_nearest_index;
   logic [DIST_W-1:0]         rsp_least_distance;

   // predictor state
   logic signed [VALUE_W-1:0] ref_words [N_ENTRIES][N_DIMS];
   logic signed [VALUE_W-1:0] qry_words [N_DIMS];
   bit                        ref_written [N_ENTRIES][N_DIMS];
   bit                        qry_written [N_DIMS];
   logic [CSR_W-1:0]          cfg_entries = RESET_NUM_ENTRIES;
   logic [CSR_W-1:0]          cfg_dims    = RESET_NUM_DIMS;

   match_type   pending_matches [$];
   int unsigned mismatches = 0;
   bit          idle_on = 1'b1;
   int unsigned pop_gap = 0;
   step_type    script [NUM_STEPS];

   nearest_neighbor_search dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .push                (push),
      .full                (full),
      .req_mode            (req_mode),
      .req_entry_index     (req_entry_index),
      .req_component_index (req_component_index),
      .req_value           (req_value),
      .req_last_component  (req_last_component),
      .empty               (empty),
      .pop                 (pop),
      .rsp_nearest_index   (rsp_nearest_index),
      .rsp_least_distance  (rsp_least_distance)
   );

   always #HALF_PERIOD clock = ~clock;

   // registers above the table size saturate
   function automatic int clamp_count(logic [CSR_W-1:0] r, int limit);
      return (int'(r) > limit) ? limit : int'(r);
   endfunction

   // squared euclidean search over the configured window, earliest entry wins ties
   function automatic match_type nearest_entry();
      int        ents;
      int        dims;
      longint    sum;
      longint    diff;
      longint    best_sum;
      match_type best;
      bit        found;
      ents = clamp_count(cfg_entries, N_ENTRIES);
      dims = clamp_count(cfg_dims, N_DIMS);
      best_sum = DIST_TOP;
      best.index = '0;
      found = 1'b0;
      for (int e = 0; e < ents; e++) begin
         sum = 0;
         for (int d = 0; d < dims; d++) begin
            diff = longint'(qry_words[d]) - longint'(ref_words[e][d]);
            sum = sum + diff * diff;
            if (sum > DIST_TOP) sum = DIST_TOP + 1;
         end
         if (sum > DIST_TOP) sum = DIST_TOP;
         if (!found || sum < best_sum) begin
            best_sum = sum;
            best.index = IDX_W'(e);
            found = 1'b1;
         end
      end
      best.distance = DIST_W'(best_sum);
      return best;
   endfunction

   // update predictor state with one accepted item; returns 1 when a search runs
   function automatic bit absorb_item(item_type it, output match_type m);
      m = '0;
      if (it.mode == MODE_LOAD) begin
         ref_words[it.entry][it.component] = it.value;
         ref_written[it.entry][it.component] = 1'b1;
         return 1'b0;
      end
      qry_words[it.component] = it.value;
      qry_written[it.component] = 1'b1;
      if (!it.last_comp) return 1'b0;
      m = nearest_entry();
      return 1'b1;
   endfunction

   // component values, with the extremes and a polarized mode for large distances
   function automatic logic signed [VALUE_W-1:0] pick_value(logic mode, bit polar);
      if (polar && $urandom_range(0, 9) < 7)
         return (mode == MODE_QUERY) ? 16'sh7FFF : 16'sh8000;
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   function automatic step_type load_step(int e, int c, int v, bit last);
      step_type s;
      s = '0;
      s.it.mode = MODE_LOAD;
      s.it.entry = IDX_W'(e);
      s.it.component = IDX_W'(c);
      s.it.value = VALUE_W'(v);
      s.it.last_comp = last;
      return s;
   endfunction

   function automatic step_type query_step(int c, int v, bit last);
      step_type s;
      s = '0;
      s.it.mode = MODE_QUERY;
      s.it.entry = IDX_W'(c ^ 21);
      s.it.component = IDX_W'(c);
      s.it.value = VALUE_W'(v);
      s.it.last_comp = last;
      return s;
   endfunction

   // search whose answer is obvious from the table contents
   function automatic step_type known_step(int c, int v, int idx, longint distance);
      step_type s;
      s = query_step(c, v, 1'b1);
      s.typed = 1'b1;
      s.want.index = IDX_W'(idx);
      s.want.distance = DIST_W'(distance);
      return s;
   endfunction

   function automatic step_type cfg_step(int entries, int dims);
      step_type s;
      s = '0;
      s.is_cfg = 1'b1;
      s.n_entries = CSR_W'(entries);
      s.n_dims = CSR_W'(dims);
      return s;
   endfunction

   // offer one item, with an optional idle burst before it
   task automatic push_item(item_type it, bit typed = 1'b0, match_type want = '0);
      match_type got;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      push <= 1'b1;
      req_mode <= it.mode;
      req_entry_index <= it.entry;
      req_component_index <= it.component;
      req_value <= it.value;
      req_last_component <= it.last_comp;
      @(posedge clock);
      while (full !== 1'b0) @(posedge clock);
      if (absorb_item(it, got)) begin
         if (typed) got = want;
         pending_matches = {pending_matches, got};
      end
   endtask

   // hold the sender until every expected result has been taken
   task automatic drain_results();
      push <= 1'b0;
      @(posedge clock);
      while (pending_matches.size() != 0) @(posedge clock);
   endtask

   // registers change only once the block has gone quiet
   task automatic set_config(logic [CSR_W-1:0] entries, logic [CSR_W-1:0] dims);
      drain_results();
      repeat (SETTLE) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_NUM_ENTRIES;
      csr_wdata <= entries;
      @(posedge clock);
      csr_index <= CSR_NUM_DIMS;
      csr_wdata <= dims;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_entries = entries;
      cfg_dims = dims;
   endtask

   // write every table and query word the next search will read
   task automatic fill_window(bit polar);
      item_type it;
      int       ents;
      int       dims;
      ents = clamp_count(cfg_entries, N_ENTRIES);
      dims = clamp_count(cfg_dims, N_DIMS);
      for (int e = 0; e < ents; e++) begin
         for (int d = 0; d < dims; d++) begin
            if (!ref_written[e][d]) begin
               it.mode = MODE_LOAD;
               it.entry = IDX_W'(e);
               it.component = IDX_W'(d);
               it.value = pick_value(MODE_LOAD, polar);
               it.last_comp = 1'($urandom_range(0, 1));
               push_item(it);
            end
         end
      end
      for (int d = 0; d < dims; d++) begin
         if (!qry_written[d]) begin
            it.mode = MODE_QUERY;
            it.entry = IDX_W'($urandom_range(0, 63));
            it.component = IDX_W'(d);
            it.value = pick_value(MODE_QUERY, polar);
            it.last_comp = 1'b0;
            push_item(it);
         end
      end
   endtask

   // random loads and query sequences inside the configured window, some stray
   task automatic run_phase(int count, bit polar, bit drain_once);
      item_type it;
      int       pick;
      int       ents;
      int       dims;
      bit       drained;
      ents = clamp_count(cfg_entries, N_ENTRIES);
      dims = clamp_count(cfg_dims, N_DIMS);
      drained = 1'b0;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         it.mode = (pick < 45) ? MODE_LOAD : MODE_QUERY;
         if (ents == 0 || $urandom_range(0, 9) == 0)
            it.entry = IDX_W'($urandom_range(0, 63));
         else
            it.entry = IDX_W'($urandom_range(0, ents - 1));
         if (dims == 0 || $urandom_range(0, 9) == 0)
            it.component = IDX_W'($urandom_range(0, 63));
         else
            it.component = IDX_W'($urandom_range(0, dims - 1));
         it.value = pick_value(it.mode, polar);
         if (it.mode == MODE_LOAD)
            it.last_comp = 1'($urandom_range(0, 1));
         else
            it.last_comp = (pick >= 85);
         if (it.mode == MODE_QUERY && it.last_comp) begin
            fill_window(polar);
            if (drain_once && !drained && pending_matches.size() != 0) begin
               drain_results();
               drained = 1'b1;
            end
         end
         push_item(it);
      end
   endtask

   // result side: random pop stalls and field checks against the oldest expectation
   always @(posedge clock) begin : result_check
      match_type want;
      if (!reset && pop && empty === 1'b0) begin
         if (pending_matches.size() == 0) begin
            $display("%0t unexpected result: expected none, actual index %0d distance %0d",
                     $time, rsp_nearest_index, rsp_least_distance);
            mismatches++;
         end else begin
            want = pending_matches.pop_front();
            if (rsp_nearest_index !== want.index) begin
               $display("%0t nearest_index mismatch: expected %0d, actual %0d",
                        $time, want.index, rsp_nearest_index);
               mismatches++;
            end
            if (rsp_least_distance !== want.distance) begin
               $display("%0t least_distance mismatch: expected %0d, actual %0d",
                        $time, want.distance, rsp_least_distance);
               mismatches++;
            end
         end
      end
      if (pop_gap != 0) begin
         pop_gap--;
         pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         pop_gap = $urandom_range(1, 4) - 1;
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   // main sequence
   initial begin
      script = '{
         load_step(0, 0, 0, 0),
         load_step(1, 0, 0, 0),
         known_step(0, 0, 0, 0),                 // equal distances, entry 0 wins
         load_step(1, 0, 32767, 0),
         known_step(0, -32768, 0, 1073741824),
         load_step(0, 0, -32768, 1),             // last flag on a load gives nothing
         known_step(0, 32767, 1, 0),
         query_step(63, 5, 0),
         load_step(63, 63, -1, 0),
         query_step(0, -32768, 1),
         cfg_step(0, 1),
         known_step(0, 123, 0, DIST_TOP),        // no entries searched
         cfg_step(2, 0),
         known_step(5, -7, 0, 0),                // no components summed
         cfg_step(2, 2),
         load_step(0, 1, 100, 0),
         load_step(1, 1, -100, 0),
         query_step(1, 0, 0),
         query_step(0, 0, 1),
         load_step(2, 0, 1, 1)
      };
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (script[i]) begin
         if (script[i].is_cfg)
            set_config(script[i].n_entries, script[i].n_dims);
         else
            push_item(script[i].it, script[i].typed, script[i].want);
      end

      // random phases over small, widest, saturated and zero settings
      set_config(7'd4, 7'd3);
      run_phase(160, 1'b0, 1'b1);
      set_config(7'd1, 7'd64);
      run_phase(90, 1'b0, 1'b0);
      set_config(7'd64, 7'd1);
      run_phase(110, 1'b0, 1'b0);
      set_config(7'd127, 7'd2);
      run_phase(90, 1'b0, 1'b0);
      set_config(7'd2, 7'd127);
      run_phase(60, 1'b0, 1'b0);
      set_config(7'd0, 7'd5);
      run_phase(40, 1'b0, 1'b0);
      set_config(7'd3, 7'd0);
      run_phase(40, 1'b0, 1'b0);
      set_config(7'd3, 7'd64);
      run_phase(40, 1'b1, 1'b0);
      set_config(CSR_W'($urandom_range(1, 6)), CSR_W'($urandom_range(1, 6)));
      idle_on = 1'b0;
      run_phase(200, 1'b0, 1'b0);

      // wind down
      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // hang guard
   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== nearest_neighbor_search.f =====
design/nns_pkg.sv
design/nns_ram.sv
design/nns_front.sv
design/nns_back.sv
design/nearest_neighbor_search.sv
tb/tb_nearest_neighbor_search.sv
